FILE: rtl/core/olt_pkg.sv
// Shared types, constants and command/status codes for the ordered list table.
package olt_pkg;

    // List geometry
    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths on the stream ports
    localparam int OP_W    = 3;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int FOUND_W = 6;
    localparam int LEN_W   = 7;

    // Command codes
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd0;
    localparam logic [OP_W-1:0] OP_GET      = 3'd1;
    localparam logic [OP_W-1:0] OP_INDEX_OF = 3'd2;
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    // Sequencer states
    typedef enum logic {
        S_IDLE,
        S_EVAL
    } state_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic              sample_en;
        logic              insert_en;
        logic              remove_en;
        logic              search_en;
        logic              get_en;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  count;
        logic [VAL_W-1:0]  value;
    } cell_ctl_t;

endpackage

FILE: rtl/core/olt_cell.sv
// One list slot: holds an element, shifts with its neighbors, flags match/select.
module olt_cell (
    input  logic                              clk,
    input  olt_pkg::cell_ctl_t                ctl,
    input  logic [olt_pkg::IDX_W-1:0]         cell_index,
    input  logic [olt_pkg::VAL_W-1:0]         left_value,
    input  logic [olt_pkg::VAL_W-1:0]         right_value,
    output logic [olt_pkg::VAL_W-1:0]         value,
    output logic                              hit,
    output logic [olt_pkg::VAL_W-1:0]         read_value
);

    logic [olt_pkg::VAL_W-1:0] value_reg;
    logic [olt_pkg::VAL_W-1:0] value_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic [olt_pkg::VAL_W-1:0] read_reg;
    logic [olt_pkg::VAL_W-1:0] read_next;
    logic [olt_pkg::POS_W-1:0] my_pos;
    logic [olt_pkg::CNT_W-1:0] my_cnt;

    assign my_pos = olt_pkg::POS_W'(cell_index);
    assign my_cnt = olt_pkg::CNT_W'(cell_index);

    // Shift up on insert, down on remove, load the new value at the insert slot
    always_comb
    begin
        value_next = value_reg;
        if (ctl.insert_en)
        begin
            if (my_pos == ctl.pos)
            begin
                value_next = ctl.value;
            end
            else if (my_pos > ctl.pos)
            begin
                value_next = left_value;
            end
        end
        else if (ctl.remove_en)
        begin
            if (my_pos >= ctl.pos)
            begin
                value_next = right_value;
            end
        end
    end

    // Flag a match inside the live part of the list, and gate out the read slot
    always_comb
    begin
        hit_next  = ctl.search_en && (my_cnt < ctl.count) && (value_reg == ctl.value);
        read_next = (ctl.get_en && (my_pos == ctl.pos)) ? value_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (ctl.sample_en)
        begin
            hit_reg  <= hit_next;
            read_reg <= read_next;
        end
    end

    assign value      = value_reg;
    assign hit        = hit_reg;
    assign read_value = read_reg;

endmodule

FILE: rtl/core/olt_reduce.sv
// Collapse the per-cell match flags and gated read values into one result.
module olt_reduce (
    input  logic [olt_pkg::CAPACITY-1:0]                     hits,
    input  logic [olt_pkg::CAPACITY-1:0][olt_pkg::VAL_W-1:0] reads,
    output logic                                             any_hit,
    output logic [olt_pkg::FOUND_W-1:0]                      found_position,
    output logic [olt_pkg::VAL_W-1:0]                        read_value
);

    logic [olt_pkg::IDX_W-1:0] first_idx;

    // Pick the lowest matching slot
    always_comb
    begin
        first_idx = '0;
        for (int i = olt_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                first_idx = olt_pkg::IDX_W'(i);
            end
        end
    end

    // Merge gated reads; at most one slot is non-zero
    always_comb
    begin
        read_value = '0;
        for (int i = 0; i < olt_pkg::CAPACITY; i++)
        begin
            read_value = read_value | reads[i];
        end
    end

    assign any_hit        = |hits;
    assign found_position = olt_pkg::FOUND_W'(first_idx);

endmodule

FILE: rtl/core/ordered_list_table_unit.sv
// Top level of the ordered list table: command decode, cell chain, result register.
// A request is registered into the cells and moves the sequencer to its evaluation
// state, which loads the result register that drives m_axis.
// No new request is taken until that state has loaded the result; it reduces the
// cells' registered match and select flags into one result.
// A stalled result holds the sequencer in its evaluation cycle until taken.
// Reset clears the length and all handshake state; element values stay undefined.
module ordered_list_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[6:0], item_value[38:7], zero fill
    input  logic [2:0]  s_axis_tuser,   // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // status[1:0], read_value[33:2],
                                        // found_position[39:34], list_length[46:40], zero fill
);

    localparam int N = olt_pkg::CAPACITY;

    olt_pkg::state_t               state_reg;
    olt_pkg::state_t               state_next;
    logic [olt_pkg::CNT_W-1:0]     count_reg;
    logic [olt_pkg::CNT_W-1:0]     count_next;
    logic [olt_pkg::STAT_W-1:0]    status_reg;
    logic [olt_pkg::STAT_W-1:0]    status_next;
    logic                          search_reg;
    logic                          search_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [47:0]                   out_data_reg;
    logic [47:0]                   out_data_next;

    logic                          accept;
    logic [olt_pkg::OP_W-1:0]      in_op;
    logic [olt_pkg::POS_W-1:0]     in_pos;
    logic [olt_pkg::VAL_W-1:0]     in_value;
    olt_pkg::cell_ctl_t            ctl;

    logic [N-1:0][olt_pkg::VAL_W-1:0] cell_value;
    logic [N-1:0][olt_pkg::VAL_W-1:0] cell_read;
    logic [N-1:0]                     cell_hit;

    logic                          any_hit;
    logic [olt_pkg::FOUND_W-1:0]   found_pos;
    logic [olt_pkg::VAL_W-1:0]     read_value;
    logic [olt_pkg::STAT_W-1:0]    final_status;
    logic [olt_pkg::LEN_W-1:0]     length_out;

    assign in_op    = s_axis_tuser;
    assign in_pos   = s_axis_tdata[6:0];
    assign in_value = s_axis_tdata[38:7];
    assign s_axis_tready = (state_reg == olt_pkg::S_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;

    // Decode the request into cell control, new length and early status
    always_comb
    begin
        ctl           = '0;
        ctl.sample_en = accept;
        ctl.pos       = in_pos;
        ctl.count     = count_reg;
        ctl.value     = in_value;
        count_next    = count_reg;
        status_next   = status_reg;
        search_next   = search_reg;
        if (accept)
        begin
            status_next = olt_pkg::ST_OK;
            search_next = 1'b0;
            unique case (in_op)
                olt_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                end
                olt_pkg::OP_GET:
                begin
                    if (olt_pkg::CNT_W'(in_pos) >= count_reg)
                    begin
                        status_next = olt_pkg::ST_RANGE;
                    end
                    else
                    begin
                        ctl.get_en = 1'b1;
                    end
                end
                olt_pkg::OP_INDEX_OF:
                begin
                    ctl.search_en = 1'b1;
                    search_next   = 1'b1;
                end
                olt_pkg::OP_INSERT:
                begin
                    if (olt_pkg::CNT_W'(in_pos) > count_reg)
                    begin
                        status_next = olt_pkg::ST_RANGE;
                    end
                    else if (count_reg >= olt_pkg::CNT_W'(N))
                    begin
                        status_next = olt_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.insert_en = 1'b1;
                        count_next    = count_reg + olt_pkg::CNT_W'(1);
                    end
                end
                olt_pkg::OP_REMOVE:
                begin
                    if (olt_pkg::CNT_W'(in_pos) >= count_reg)
                    begin
                        status_next = olt_pkg::ST_RANGE;
                    end
                    else
                    begin
                        ctl.remove_en = 1'b1;
                        count_next    = count_reg - olt_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = olt_pkg::ST_OK;
                end
            endcase
        end
    end

    // Chain of slots, each fed by its lower and upper neighbor
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic [olt_pkg::VAL_W-1:0] left_v;
            logic [olt_pkg::VAL_W-1:0] right_v;

            if (g == 0)
            begin : g_first
                assign left_v = '0;
            end
            else
            begin : g_mid_l
                assign left_v = cell_value[g-1];
            end

            if (g == N - 1)
            begin : g_last
                assign right_v = '0;
            end
            else
            begin : g_mid_r
                assign right_v = cell_value[g+1];
            end

            olt_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .cell_index  (olt_pkg::IDX_W'(g)),
                .left_value  (left_v),
                .right_value (right_v),
                .value       (cell_value[g]),
                .hit         (cell_hit[g]),
                .read_value  (cell_read[g])
            );
        end
    endgenerate

    olt_reduce u_reduce (
        .hits           (cell_hit),
        .reads          (cell_read),
        .any_hit        (any_hit),
        .found_position (found_pos),
        .read_value     (read_value)
    );

    assign length_out   = olt_pkg::LEN_W'(count_reg);
    assign final_status = (search_reg && !any_hit) ? olt_pkg::ST_NOT_FOUND : status_reg;

    // Sequencer: take a request, then evaluate and load the result register
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            olt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = olt_pkg::S_EVAL;
                end
            end
            olt_pkg::S_EVAL:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, length_out, found_pos, read_value, final_status};
                    state_next     = olt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = olt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olt_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            search_reg    <= 1'b0;
            status_reg    <= olt_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            search_reg    <= search_next;
            status_reg    <= status_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: rtl/core/olt_checker.sv
// Port-level checks for the ordered list table, bound to the top level.
module olt_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // Drop ready for the evaluation cycle after each request
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken during evaluation");

    // Never report more elements than slots
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[46:40] <= 7'(olt_pkg::CAPACITY))
        else $error("length beyond capacity");

    // Report full only with every slot in use
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == olt_pkg::ST_FULL
            |-> m_axis_tdata[46:40] == 7'(olt_pkg::CAPACITY))
        else $error("full status with free slots");

    // Zero the read and found fields unless the request succeeded
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != olt_pkg::ST_OK
            |-> m_axis_tdata[39:2] == '0)
        else $error("payload present on failed request");

endmodule

bind ordered_list_table_unit olt_checker u_olt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
